@@ hdl/plaw_pkg.sv @@
// package for the pid loop with angle wrap
// holds widths, the turn constant, register indexes and the config struct
// no dependencies
package plaw_pkg;

  localparam int COUNTS_PER_TURN = 8192;
  localparam int HALF_TURN       = COUNTS_PER_TURN / 2;

  localparam int DATA_W = 16;  // setpoint, measured, gains, drive
  localparam int LIM_W  = 15;  // output and integral limits
  localparam int ERR_W  = 18;  // error after wrap, and its first difference
  localparam int ACC_W  = 24;  // integral in 1/256 output units
  localparam int IDX_W  = 3;   // config register index

  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEG_GAIN     = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_OUTPUT_LIMIT   = 3'd3,
    REG_INTEGRAL_LIMIT = 3'd4,
    REG_ANGLE_WRAP     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integ_gain;
    logic signed [DATA_W-1:0] deriv_gain;
    logic [LIM_W-1:0]         output_limit;
    logic [LIM_W-1:0]         integral_limit;
    logic                     angle_wrap;
  } cfg_t;

endpackage

@@ hdl/plaw_in_if.sv @@
// input channel of the pid loop: setpoint, measured sample and clear
// depends on plaw_pkg
interface plaw_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [plaw_pkg::DATA_W-1:0] setpoint;
  logic signed [plaw_pkg::DATA_W-1:0] measured;
  logic                               clear;

  modport source (output valid, setpoint, measured, clear, input ready);
  modport sink (input valid, setpoint, measured, clear, output ready);
endinterface

@@ hdl/plaw_out_if.sv @@
// result channel of the pid loop: drive and the two clamp flags
// depends on plaw_pkg
interface plaw_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [plaw_pkg::DATA_W-1:0] drive;
  logic                               output_clamped;
  logic                               integral_clamped;

  modport source (output valid, drive, output_clamped, integral_clamped, input ready);
  modport sink (input valid, drive, output_clamped, integral_clamped, output ready);
endinterface

@@ hdl/plaw_cfg_if.sv @@
// config write channel of the pid loop: register index and write data
// depends on plaw_pkg
interface plaw_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [plaw_pkg::IDX_W-1:0]  index;
  logic [plaw_pkg::DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/plaw_dpath.sv @@
// pipelined pid datapath: error and wrap, products, integral clamp and output saturation
// holds the last error and the integral; depends on plaw_pkg
module plaw_dpath #(
  parameter int COUNTS_PER_TURN = plaw_pkg::COUNTS_PER_TURN
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  plaw_pkg::cfg_t                     cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [plaw_pkg::DATA_W-1:0] setpoint,
  input  logic signed [plaw_pkg::DATA_W-1:0] measured,
  input  logic                               clear,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [plaw_pkg::DATA_W-1:0] drive,
  output logic                               output_clamped,
  output logic                               integral_clamped
);

  localparam int DW   = plaw_pkg::DATA_W;
  localparam int EW   = plaw_pkg::ERR_W;
  localparam int AW   = plaw_pkg::ACC_W;
  localparam int LW   = plaw_pkg::LIM_W;
  localparam int PW   = DW + EW;     // product width
  localparam int SW   = AW + PW - AW + 1; // integral plus one product
  localparam int TW   = PW + 2;      // sum of three terms
  localparam int QW   = TW - 8;      // sum after the 1/256 scale

  localparam logic signed [EW-1:0] HALF_C = EW'(COUNTS_PER_TURN / 2);
  localparam logic signed [EW-1:0] TURN_C = EW'(COUNTS_PER_TURN);

  logic adv;

  // stage 0: input register
  logic                 s0_vld_r;
  logic signed [DW-1:0] s0_sp_r, s0_ms_r;
  logic                 s0_clr_r;

  // stage 1: wrapped error
  logic                 s1_vld_r;
  logic signed [EW-1:0] s1_err_r;
  logic                 s1_clr_r;
  logic signed [EW-1:0] err_raw, err_wrap;

  // stage 2: products
  logic                 s2_vld_r;
  logic                 s2_clr_r;
  logic signed [PW-1:0] p_r, d_r, ip_r;
  logic signed [PW-1:0] p_nxt, d_nxt, ip_nxt;
  logic signed [EW-1:0] err_diff;

  // state
  logic signed [EW-1:0] last_err_r;
  logic signed [AW-1:0] acc_r;

  // stage 3 logic and result register
  logic signed [SW-1:0] acc_sum, ilim;
  logic signed [AW-1:0] acc_nxt;
  logic                 ic_nxt;
  logic signed [TW-1:0] total;
  logic signed [QW-1:0] scaled, olim;
  logic signed [DW-1:0] drv_nxt;
  logic                 oc_nxt;

  logic                 out_vld_r;
  logic signed [DW-1:0] drive_r;
  logic                 oc_r, ic_r;

  // the whole pipe moves unless a result waits on a stalled receiver
  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r  <= in_valid;
      s1_vld_r  <= s0_vld_r;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      s0_sp_r  <= setpoint;
      s0_ms_r  <= measured;
      s0_clr_r <= clear;
    end
  end

  always_comb begin
    err_raw  = EW'(s0_sp_r) - EW'(s0_ms_r);
    err_wrap = err_raw;
    if (cfg.angle_wrap) begin
      if (err_raw > HALF_C) begin
        err_wrap = err_raw - TURN_C;
      end else if (err_raw < -HALF_C) begin
        err_wrap = err_raw + TURN_C;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s0_vld_r) begin
      s1_err_r <= err_wrap;
      s1_clr_r <= s0_clr_r;
    end
  end

  always_comb begin
    err_diff = s1_err_r - last_err_r;
    p_nxt    = PW'(cfg.prop_gain) * PW'(s1_err_r);
    d_nxt    = PW'(cfg.deriv_gain) * PW'(err_diff);
    ip_nxt   = PW'(cfg.integ_gain) * PW'(s1_err_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
    end else if (adv && s1_vld_r) begin
      last_err_r <= s1_clr_r ? '0 : s1_err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_vld_r) begin
      p_r      <= p_nxt;
      d_r      <= d_nxt;
      ip_r     <= ip_nxt;
      s2_clr_r <= s1_clr_r;
    end
  end

  always_comb begin
    acc_sum = SW'(acc_r) + SW'(ip_r);
    ilim    = $signed({(SW - LW - 8)'(0), cfg.integral_limit, 8'd0});
    acc_nxt = AW'(acc_sum);
    ic_nxt  = 1'b0;
    if (acc_sum > ilim) begin
      acc_nxt = AW'(ilim);
      ic_nxt  = 1'b1;
    end else if (acc_sum < -ilim) begin
      acc_nxt = AW'(-ilim);
      ic_nxt  = 1'b1;
    end
    total   = TW'(p_r) + TW'(acc_nxt) + TW'(d_r);
    // arithmetic shift by dropping the low byte rounds toward minus infinity
    scaled  = total[TW-1:8];
    olim    = $signed({(QW - LW)'(0), cfg.output_limit});
    drv_nxt = DW'(scaled);
    oc_nxt  = 1'b0;
    if (scaled > olim) begin
      drv_nxt = DW'(olim);
      oc_nxt  = 1'b1;
    end else if (scaled < -olim) begin
      drv_nxt = DW'(-olim);
      oc_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (adv && s2_vld_r) begin
      acc_r <= s2_clr_r ? '0 : acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_vld_r) begin
      drive_r <= s2_clr_r ? '0 : drv_nxt;
      oc_r    <= s2_clr_r ? 1'b0 : oc_nxt;
      ic_r    <= s2_clr_r ? 1'b0 : ic_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign drive            = drive_r;
  assign output_clamped   = oc_r;
  assign integral_clamped = ic_r;

  a_drive_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_vld_r) |=>
      (drive_r <= $signed({1'b0, $past(cfg.output_limit)}) &&
       drive_r >= -$signed({1'b0, $past(cfg.output_limit)})))
    else $error("drive beyond output limit");

  a_integral_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_vld_r) |=>
      (acc_r <= $signed({1'b0, $past(cfg.integral_limit), 8'd0}) &&
       acc_r >= -$signed({1'b0, $past(cfg.integral_limit), 8'd0})))
    else $error("integral beyond integral limit");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_vld_r && s2_clr_r) |=>
      (acc_r == '0 && drive_r == '0 && !oc_r && !ic_r))
    else $error("clear did not zero the integral and result");

  a_clear_last_err: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_vld_r && s1_clr_r) |=> (last_err_r == '0))
    else $error("clear did not zero the last error");

endmodule

@@ hdl/pid_loop_angle_wrap.sv @@
// top level of the positional pid controller with clamped integral and angle wrap
// holds the config registers and the channel handshakes around plaw_dpath
// depends on plaw_pkg, plaw_in_if, plaw_out_if, plaw_cfg_if
//
// usage:
//   in_ch carries one word per control tick: setpoint, measured and clear.
//   out_ch returns one word for each input word, in order: drive and the
//   output and integral clamp flags.
//   cfg_ch writes gains, limits and the angle-wrap enable by register index;
//   it is always ready, and indexes beyond the list are dropped.
// pipeline and rate:
//   a word accepted on in_ch passes the input register, the error stage,
//   the product stage and the result register before its result shows on
//   out_ch. one word per cycle is taken while out_ch does not stall.
// stall:
//   while a result sits on out_ch with ready low, the whole pipe holds and
//   in_ch.ready is low; the controller state moves only with the pipe.
// reset:
//   the config registers, the last error and the integral read as zero, the pipe
//   is empty and in_ch.ready is high.
module pid_loop_angle_wrap #(
  parameter int COUNTS_PER_TURN = plaw_pkg::COUNTS_PER_TURN
) (
  input  logic       clk,
  input  logic       rst_n,
  plaw_cfg_if.sink   cfg_ch,
  plaw_in_if.sink    in_ch,
  plaw_out_if.source out_ch
);

  plaw_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      case (plaw_pkg::reg_idx_t'(cfg_ch.index))
        plaw_pkg::REG_PROP_GAIN: begin
          cfg_r.prop_gain <= $signed(cfg_ch.data);
        end
        plaw_pkg::REG_INTEG_GAIN: begin
          cfg_r.integ_gain <= $signed(cfg_ch.data);
        end
        plaw_pkg::REG_DERIV_GAIN: begin
          cfg_r.deriv_gain <= $signed(cfg_ch.data);
        end
        plaw_pkg::REG_OUTPUT_LIMIT: begin
          cfg_r.output_limit <= cfg_ch.data[plaw_pkg::LIM_W-1:0];
        end
        plaw_pkg::REG_INTEGRAL_LIMIT: begin
          cfg_r.integral_limit <= cfg_ch.data[plaw_pkg::LIM_W-1:0];
        end
        plaw_pkg::REG_ANGLE_WRAP: begin
          cfg_r.angle_wrap <= cfg_ch.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  plaw_dpath #(
    .COUNTS_PER_TURN (COUNTS_PER_TURN)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .setpoint         (in_ch.setpoint),
    .measured         (in_ch.measured),
    .clear            (in_ch.clear),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .drive            (out_ch.drive),
    .output_clamped   (out_ch.output_clamped),
    .integral_clamped (out_ch.integral_clamped)
  );

endmodule
